>>> hw/rtl/rgb_led_group_blink_driver_defines.svh
// Assertion macros used by the LED group blink driver checker.
`ifndef RGB_LED_GROUP_BLINK_DRIVER_DEFINES_SVH
`define RGB_LED_GROUP_BLINK_DRIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RGBLD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbld: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RGBLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbld: next-cycle check failed");

`endif

>>> hw/rtl/rgbld_pkg.sv
// Shared constants and types of the LED group blink driver.
package rgbld_pkg;

    localparam int COMBO_COUNT  = 12;
    localparam int BLINK_PERIOD = 50;
    localparam int FRAME_W      = 25;
    localparam int COLOR_W      = 3;
    localparam int COLORS_W     = COMBO_COUNT * COLOR_W;
    localparam int COMBO_W      = 4;
    localparam int OP_W         = 2;
    localparam int TICK_W       = 6;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 32;

    localparam logic [COLOR_W-1:0]  COLOR_BLACK   = 3'd7;
    localparam logic [7:0]          VEC_RED       = 8'h9A;
    localparam logic [7:0]          VEC_GREEN     = 8'h56;
    localparam logic [7:0]          VEC_BLUE      = 8'h2E;
    localparam logic [COLORS_W-1:0] COLORS_RESET  = 36'h249388C00;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_ON    = 2'd1,
        OP_OFF   = 2'd2,
        OP_BLINK = 2'd3
    } op_t;

    // LED set and dark/lit pattern produced by the draw unit
    typedef struct packed {
        logic [FRAME_W-1:0] mask;
        logic [FRAME_W-1:0] on;
    } draw_t;

endpackage

>>> hw/rtl/rgbld_draw.sv
// Shared draw unit: LED mask and lit pattern of one combo in one color.
module rgbld_draw (
    input  logic [rgbld_pkg::COMBO_W-1:0] idx,
    input  logic [rgbld_pkg::COLOR_W-1:0] color,
    output rgbld_pkg::draw_t              result
);
    import rgbld_pkg::*;

    typedef enum logic [1:0] {
        KIND_RGB    = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_PAIR   = 2'd2,
        KIND_NONE   = 2'd3
    } led_kind_t;

    led_kind_t   kind;
    logic [4:0]  offset;
    logic [4:0]  triple;
    logic [2:0]  bitpos;
    logic [2:0]  rgb;
    logic [2:0]  pmask;
    logic [2:0]  pon;

    assign triple = {idx, 1'b0} + {1'b0, idx};
    assign bitpos = ~color;
    assign rgb    = {VEC_BLUE[bitpos], VEC_GREEN[bitpos], VEC_RED[bitpos]};

    always_comb
    begin
        kind   = KIND_NONE;
        offset = '0;
        case (idx) inside
            [4'd0:4'd5]:
            begin
                kind   = KIND_RGB;
                offset = triple;
            end
            [4'd6:4'd10]:
            begin
                kind   = KIND_SINGLE;
                offset = {1'b0, idx} + 5'd12;
            end
            4'd11:
            begin
                kind   = KIND_PAIR;
                offset = 5'd23;
            end
            default:
            begin
                kind   = KIND_NONE;
                offset = '0;
            end
        endcase
    end

    always_comb
    begin
        case (kind)
            KIND_RGB:
            begin
                pmask = 3'b111;
                pon   = rgb;
            end
            KIND_SINGLE:
            begin
                pmask = 3'b001;
                pon   = {2'b00, (color != COLOR_BLACK)};
            end
            KIND_PAIR:
            begin
                pmask = 3'b011;
                pon   = {1'b0, rgb[1:0]};
            end
            default:
            begin
                pmask = 3'b000;
                pon   = 3'b000;
            end
        endcase
    end

    assign result.mask = FRAME_W'(pmask) << offset;
    assign result.on   = FRAME_W'(pon) << offset;

endmodule

>>> hw/rtl/rgb_led_group_blink_driver.sv
// Top level of the 25-LED, 12-combo blink driver with a shared draw unit.
// Each item passes EXEC, then SEND loads the output register; one item is taken
// at a time. A redrawing tick holds the input through the BLINK sweep, as the
// single draw unit visits the 12 combos one per cycle.
// Reset (rst_n low, asynchronous): frame all dark, flags clear, blink phase one,
// tick count zero, colors at their default, output empty. No clearing pass.
module rgb_led_group_blink_driver (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: combo_colors, combo one in bits 2..0
    input  logic                            cfg_wen,
    input  logic [rgbld_pkg::COLORS_W-1:0]  cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rgbld_pkg::S_TDATA_W-1:0] s_tdata,  // [3:0] combo, [4] blink_enable, rest 0
    input  logic [rgbld_pkg::OP_W-1:0]      s_tuser,  // [1:0] op
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rgbld_pkg::M_TDATA_W-1:0] m_tdata,  // [24:0] frame_bits, rest 0
    output logic                            m_tuser   // [0] refresh
);
    import rgbld_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_BLINK = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    localparam logic [COMBO_W-1:0] LAST_ITER  = COMBO_W'(COMBO_COUNT - 1);
    localparam logic [COMBO_W-1:0] MAX_COMBO  = COMBO_W'(COMBO_COUNT);
    localparam logic [TICK_W-1:0]  PERIOD_TOP = TICK_W'(BLINK_PERIOD);

    state_t                state_reg, state_next;
    logic [COLORS_W-1:0]   colors_reg;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [COMBO_COUNT-1:0] lit_reg, lit_next;
    logic [COMBO_COUNT-1:0] blink_reg, blink_next;
    logic                  phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [COMBO_W-1:0]    iter_reg, iter_next;
    op_t                   op_reg, op_next;
    logic [COMBO_W-1:0]    combo_reg, combo_next;
    logic                  en_reg, en_next;
    logic                  refresh_reg, refresh_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]    out_frame_reg, out_frame_next;
    logic                  out_refresh_reg, out_refresh_next;

    logic [COMBO_W-1:0]    combo_idx;
    logic                  combo_ok;
    logic [COMBO_W-1:0]    draw_idx;
    logic [COLOR_W-1:0]    draw_color;
    logic [COLOR_W-1:0]    cur_color;
    logic [5:0]            color_off;
    draw_t                 draw;
    logic [FRAME_W-1:0]    drawn_frame;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_frame_reg);
    assign m_tuser  = out_refresh_reg;

    // Combo numbers start at one; anything outside 1..12 leaves the state alone.
    assign combo_idx = combo_reg - COMBO_W'(1);
    assign combo_ok  = (combo_reg != '0) && (combo_reg <= MAX_COMBO);

    // One draw unit serves both the single-combo ops and the redraw sweep.
    assign draw_idx  = (state_reg == ST_BLINK) ? iter_reg : combo_idx;
    assign color_off = {1'b0, draw_idx, 1'b0} + {2'b00, draw_idx};
    assign cur_color = colors_reg[color_off +: COLOR_W];

    always_comb
    begin
        if (state_reg == ST_BLINK)
        begin
            draw_color = (phase_reg && lit_reg[iter_reg]) ? cur_color : COLOR_BLACK;
        end
        else
        begin
            draw_color = (op_reg == OP_OFF) ? COLOR_BLACK : cur_color;
        end
    end

    rgbld_draw u_draw (
        .idx    (draw_idx),
        .color  (draw_color),
        .result (draw)
    );

    // Frame bit 1 means dark: clear a masked bit when its LED is lit.
    assign drawn_frame = (frame_reg & ~draw.mask) | (draw.mask & ~draw.on);

    always_comb
    begin
        state_next       = state_reg;
        frame_next       = frame_reg;
        lit_next         = lit_reg;
        blink_next       = blink_reg;
        phase_next       = phase_reg;
        tick_next        = tick_reg;
        iter_next        = iter_reg;
        op_next          = op_reg;
        combo_next       = combo_reg;
        en_next          = en_reg;
        refresh_next     = refresh_reg;
        out_valid_next   = out_valid_reg;
        out_frame_next   = out_frame_reg;
        out_refresh_next = out_refresh_reg;

        // drop the result once the sink takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    combo_next = s_tdata[COMBO_W-1:0];
                    en_next    = s_tdata[COMBO_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                refresh_next = (op_reg == OP_TICK);
                state_next   = ST_SEND;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (tick_reg >= PERIOD_TOP)
                        begin
                            // start the redraw sweep over all combos
                            tick_next  = '0;
                            iter_next  = '0;
                            state_next = ST_BLINK;
                        end
                        else
                        begin
                            tick_next = tick_reg + TICK_W'(1);
                        end
                    end
                    OP_ON:
                    begin
                        if (combo_ok)
                        begin
                            frame_next          = drawn_frame;
                            lit_next[combo_idx] = 1'b1;
                        end
                    end
                    OP_OFF:
                    begin
                        if (combo_ok)
                        begin
                            frame_next          = drawn_frame;
                            lit_next[combo_idx] = 1'b0;
                        end
                    end
                    OP_BLINK:
                    begin
                        if (combo_ok)
                        begin
                            blink_next[combo_idx] = en_reg;
                        end
                    end
                    default:
                    begin
                        state_next = ST_SEND;
                    end
                endcase
            end
            ST_BLINK:
            begin
                // visit one combo per cycle, redrawing it if it blinks
                if (blink_reg[iter_reg])
                begin
                    frame_next = drawn_frame;
                end
                if (iter_reg == LAST_ITER)
                begin
                    phase_next = ~phase_reg;
                    state_next = ST_SEND;
                end
                else
                begin
                    iter_next = iter_reg + COMBO_W'(1);
                end
            end
            ST_SEND:
            begin
                // load the output register once it is free or being emptied
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_frame_next   = frame_reg;
                    out_refresh_next = refresh_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_reg     <= '1;
            lit_reg       <= '0;
            blink_reg     <= '0;
            phase_reg     <= 1'b1;
            tick_reg      <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            lit_reg       <= lit_next;
            blink_reg     <= blink_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: held item and output data need no reset
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        combo_reg       <= combo_next;
        en_reg          <= en_next;
        refresh_reg     <= refresh_next;
        out_frame_reg   <= out_frame_next;
        out_refresh_reg <= out_refresh_next;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg <= COLORS_RESET;
        end
        else if (cfg_wen)
        begin
            colors_reg <= cfg_wdata;
        end
    end

endmodule

>>> hw/rtl/rgbld_checker.sv
// Port-level checker of the LED group blink driver and its bind.
`include "rgb_led_group_blink_driver_defines.svh"

module rgbld_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rgbld_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import rgbld_pkg::*;

    // a stalled result holds
    `RGBLD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // the block works on one item at a time
    `RGBLD_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

    // a fresh result comes with the input side open again
    `RGBLD_ASSERT_NOW(a_ready_with_result, $rose(m_tvalid), s_tready)

    // pad bits above the frame stay zero
    `RGBLD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:FRAME_W] == '0)

endmodule

bind rgb_led_group_blink_driver rgbld_checker u_rgbld_checker (.*);
